>>> sv/ujse_pkg.sv
// ----------------------------------------------------------------------------
// ujse_pkg: shared types, constants and helpers for the JSON string escaper
// Character codes, the held-sequence state record and the result record
// that passes from the encoder to the output shift line.
// ----------------------------------------------------------------------------
package ujse_pkg;

    // Deepest expansion of one input byte: a surrogate pair
    localparam int MaxResults = 12;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;

    // Offset that brings 10..15 onto 'A'..'F'
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

    // Surrogate pair constants
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] SURR_HI   = 16'hD800;
    localparam logic [15:0] SURR_LO   = 16'hDC00;

    // Pending multi-byte sequence
    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] cont0;
        logic [7:0] cont1;
        logic [1:0] needed;
        logic [1:0] held;
    } seq_state_t;

    // Bytes produced by one input byte, element 0 goes out first
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [3:0]                 count;
    } result_t;

    // Upper-case hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        if (d < 4'd10)
            return CH_ZERO + {4'b0, d};
        else
            return HEX_ALPHA_BASE + {4'b0, d};
    endfunction

    // \uXXXX sequence of a 16-bit code unit
    function automatic logic [5:0][7:0] u16_escape(input logic [15:0] v);
        logic [5:0][7:0] e;
        e[0] = CH_BSL;
        e[1] = CH_LO_U;
        e[2] = hex_digit(v[15:12]);
        e[3] = hex_digit(v[11:8]);
        e[4] = hex_digit(v[7:4]);
        e[5] = hex_digit(v[3:0]);
        return e;
    endfunction

endpackage

>>> sv/ujse_if.sv
// ----------------------------------------------------------------------------
// ujse_if: valid/ready channels of the JSON string escaper
// Input channel carries raw text bytes, output channel escaped bytes.
// ----------------------------------------------------------------------------
interface ujse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface ujse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, out_byte, run_last, text_end, input ready);
    modport sink   (input valid, out_byte, run_last, text_end, output ready);
endinterface

>>> sv/ujse_encode.sv
// ----------------------------------------------------------------------------
// ujse_encode: one-byte escape and UTF-8 decode step
// From the held sequence and a new byte, produce the escaped bytes this
// byte causes and the sequence state that follows it.
// ----------------------------------------------------------------------------
module ujse_encode
    import ujse_pkg::*;
(
    input  seq_state_t st,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    input  logic       escape_slash,
    output seq_state_t st_next,
    output result_t    res
);

    logic [5:0][7:0] fr;
    logic [2:0]      fr_n;
    logic [1:0]      fr_need;
    logic [2:0][7:0] fl;
    logic [1:0]      fl_n;
    logic [1:0]      off;
    logic [3:0]      j;
    logic            is_cont;
    logic [20:0]     v21;
    logic [20:0]     vs;
    logic [15:0]     hi;
    logic [15:0]     lo;

    // Handle the byte as if no sequence were pending
    always_comb
    begin
        fr      = '0;
        fr[0]   = in_byte;
        fr_n    = 3'd1;
        fr_need = 2'd0;
        case (in_byte)
            CH_SLASH:
            begin
                if (escape_slash)
                begin
                    fr[0] = CH_BSL;
                    fr[1] = in_byte;
                    fr_n  = 3'd2;
                end
            end
            CH_QUOTE, CH_BSL:
            begin
                fr[0] = CH_BSL;
                fr[1] = in_byte;
                fr_n  = 3'd2;
            end
            CH_BS:  begin fr[0] = CH_BSL; fr[1] = CH_LO_B; fr_n = 3'd2; end
            CH_FF:  begin fr[0] = CH_BSL; fr[1] = CH_LO_F; fr_n = 3'd2; end
            CH_LF:  begin fr[0] = CH_BSL; fr[1] = CH_LO_N; fr_n = 3'd2; end
            CH_CR:  begin fr[0] = CH_BSL; fr[1] = CH_LO_R; fr_n = 3'd2; end
            CH_TAB: begin fr[0] = CH_BSL; fr[1] = CH_LO_T; fr_n = 3'd2; end
            default:
            begin
                if (in_byte < CH_SPACE)
                begin
                    fr   = u16_escape({8'h00, in_byte});
                    fr_n = 3'd6;
                end
                else if (in_byte[7])
                begin
                    // Lead byte: open a sequence unless the text ends here
                    if (in_byte[7:5] == 3'b110)
                        fr_need = 2'd1;
                    else if (in_byte[7:4] == 4'b1110)
                        fr_need = 2'd2;
                    else if (in_byte[7:3] == 5'b11110)
                        fr_need = 2'd3;
                    if (end_of_text)
                        fr_need = 2'd0;
                    if (fr_need != 2'd0)
                        fr_n = 3'd0;
                end
            end
        endcase
    end

    // Held bytes as they go out raw
    always_comb
    begin
        fl[0] = st.lead;
        fl[1] = st.cont0;
        fl[2] = st.cont1;
        case (st.held)
            2'd0:    fl_n = 2'd1;
            2'd1:    fl_n = 2'd2;
            default: fl_n = 2'd3;
        endcase
    end

    // Code point of a completed sequence
    always_comb
    begin
        v21 = {st.lead[2:0], st.cont0[5:0], st.cont1[5:0], in_byte[5:0]};
        vs  = v21 - SUPP_BASE;
        hi  = SURR_HI + {6'b0, vs[19:10]};
        lo  = SURR_LO + {6'b0, vs[9:0]};
    end

    // Select the step and assemble the result
    always_comb
    begin
        is_cont = (in_byte[7:6] == 2'b10);
        st_next = st;
        res     = '0;
        off     = 2'd0;
        j       = 4'd0;
        if (st.needed != 2'd0 && is_cont && st.needed == 2'd1)
        begin
            // Final continuation: emit the code point
            st_next = '0;
            if (st.held == 2'd0)
            begin
                res.bytes[5:0] = u16_escape({5'b0, st.lead[4:0], in_byte[5:0]});
                res.count      = 4'd6;
            end
            else if (st.held == 2'd1)
            begin
                res.bytes[5:0] = u16_escape({st.lead[3:0], st.cont0[5:0], in_byte[5:0]});
                res.count      = 4'd6;
            end
            else
            begin
                res.bytes[5:0]  = u16_escape(hi);
                res.bytes[11:6] = u16_escape(lo);
                res.count       = 4'd12;
            end
        end
        else if (st.needed != 2'd0 && is_cont && !end_of_text)
        begin
            // Hold the continuation byte
            if (st.held[0])
                st_next.cont1 = in_byte;
            else
                st_next.cont0 = in_byte;
            st_next.held   = st.held + 2'd1;
            st_next.needed = st.needed - 2'd1;
        end
        else
        begin
            // Drop any held bytes raw, then handle the byte afresh
            if (st.needed != 2'd0)
                off = fl_n;
            st_next = '0;
            if (fr_need != 2'd0)
            begin
                st_next.lead   = in_byte;
                st_next.needed = fr_need;
            end
            for (int i = 0; i < MaxResults; i++)
            begin
                j = 4'(i) - {2'b0, off};
                if (4'(i) < {2'b0, off})
                    res.bytes[i] = fl[2'(i)];
                else if (j < {1'b0, fr_n})
                    res.bytes[i] = fr[j[2:0]];
            end
            res.count = {2'b0, off} + {1'b0, fr_n};
        end
    end

endmodule

>>> sv/utf8_json_string_escaper.sv
// ----------------------------------------------------------------------------
// utf8_json_string_escaper: UTF-8 text to ASCII JSON string escaper
// Takes one raw byte per transfer and emits the escaped text byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   : one text byte per transfer, end_of_text on the final one.
//   out_ch (source) : escaped bytes; run_last marks the last byte caused by
//                     an input byte, text_end the last byte of the text.
//   cfg_we/cfg_data : write escape_slash while the block is idle.
// An input byte is decoded in the cycle it transfers; its escaped bytes sit
// in a 12-byte output shift line and the first one is offered on the next
// cycle. An input byte that yields N bytes holds the output until all N have
// transferred (N = 0 for a held lead or continuation byte, 1 for plain ASCII,
// up to 12 for a surrogate pair); in_ch accepts again in the cycle the last of
// them transfers, so plain text runs at one byte per cycle while out_ch.ready
// stays high. The shift line and its output port set this rate.
// A stalled receiver holds the current byte and keeps in_ch closed while any
// byte waits that does not transfer in that cycle. Reset drops any pending
// sequence, empties the output and clears escape_slash.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper
    import ujse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ujse_in_if.sink       in_ch,
    ujse_out_if.source    out_ch,
    input  logic          cfg_we,
    input  logic          cfg_data
);

    seq_state_t                 st_reg;
    seq_state_t                 st_next;
    result_t                    res;
    logic [MaxResults-1:0][7:0] buf_reg;
    logic [MaxResults-1:0][7:0] buf_next;
    logic [3:0]                 cnt_reg;
    logic [3:0]                 cnt_next;
    logic                       eot_reg;
    logic                       eot_next;
    logic                       esc_reg;
    logic                       in_fire;
    logic                       out_fire;

    // Escape step
    ujse_encode u_encode (
        .st           (st_reg),
        .in_byte      (in_ch.in_byte),
        .end_of_text  (in_ch.end_of_text),
        .escape_slash (esc_reg),
        .st_next      (st_next),
        .res          (res)
    );

    // Handshakes
    assign out_ch.valid    = (cnt_reg != 4'd0);
    assign out_fire        = out_ch.valid && out_ch.ready;
    assign in_ch.ready     = (cnt_reg == 4'd0) || (out_fire && cnt_reg == 4'd1);
    assign in_fire         = in_ch.valid && in_ch.ready;

    // Output payload from the head of the shift line
    assign out_ch.out_byte = buf_reg[0];
    assign out_ch.run_last = (cnt_reg == 4'd1);
    assign out_ch.text_end = (cnt_reg == 4'd1) && eot_reg;

    // Load a new result or advance on each output transfer
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        eot_next = eot_reg;
        if (in_fire)
        begin
            buf_next = res.bytes;
            cnt_next = res.count;
            eot_next = in_ch.end_of_text;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MaxResults - 1; i++)
                buf_next[i] = buf_reg[i + 1];
            buf_next[MaxResults-1] = '0;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            cnt_reg <= 4'd0;
            esc_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                st_reg <= st_next;
            cnt_reg <= cnt_next;
            if (cfg_we)
                esc_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        eot_reg <= eot_next;
    end

    // Intake stays closed while more than one byte waits
    a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg > 4'd1 |-> !in_ch.ready)
        else $error("input ready while output line holds several bytes");

    // A byte that is not the last of its run is followed by another
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_ch.run_last |=> out_ch.valid)
        else $error("output run ended without run_last");

    // The output line never holds more than one expansion
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(MaxResults))
        else $error("output count beyond expansion depth");

    // A surrogate pair needs all three held bytes
    a_pair_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res.count == 4'd12 |-> st_reg.held == 2'd2)
        else $error("twelve-byte result without a four-byte sequence");

endmodule
